// ===== sv/trd_pkg.sv =====
// Shared types and constants for the run-length TGA pixel decoder.
// No dependencies; imported by the step logic and the top level.
`default_nettype none

package trd_pkg;

  localparam logic [7:0] RunBias = 8'd127;
  localparam logic [1:0] LastByte3 = 2'd2;
  localparam logic [1:0] LastByte4 = 2'd3;
  localparam int unsigned PaddrW = 3;

  // Configuration register indexes (byte address bit 2).
  typedef enum logic {
    REG_FOUR_BYTE   = 1'b0,
    REG_PIXEL_TOTAL = 1'b1
  } reg_idx_e;

  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_PIXEL  = 1'b1
  } phase_e;

  typedef struct packed {
    phase_e          phase;
    logic            is_run;
    logic [7:0]      left;
    logic [1:0]      bip;
    logic [2:0][7:0] px;
    logic [31:0]     idx;
  } dec_state_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_count;
    logic [31:0] first_index;
    logic        clipped;
    logic        frame_done;
  } run_item_t;

endpackage

`default_nettype wire

// ===== sv/trd_if.sv =====
// Valid/ready channel interfaces for the decoder input bytes and run items.
// Depends on nothing.
`default_nettype none

interface trd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;
  modport source (output valid, data_byte, frame_start, input ready);
  modport sink (input valid, data_byte, frame_start, output ready);
endinterface

interface trd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [7:0]  repeat_count;
  logic [31:0] first_index;
  logic        clipped;
  logic        frame_done;
  modport source (output valid, red, green, blue, alpha, repeat_count, first_index,
                  clipped, frame_done, input ready);
  modport sink (input valid, red, green, blue, alpha, repeat_count, first_index,
                clipped, frame_done, output ready);
endinterface

`default_nettype wire

// ===== sv/trd_step.sv =====
// Single-byte decode step: next decoder state and the optional run item.
// Depends on trd_pkg.
`default_nettype none

module trd_step
  import trd_pkg::*;
(
  input  dec_state_t  state_i,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  input  logic        four_byte_i,
  input  logic [31:0] pixel_total_i,
  output dec_state_t  state_o,
  output run_item_t   item_o,
  output logic        item_valid_o
);

  dec_state_t      cur;
  logic [32:0]     diff;
  logic [31:0]     remaining;
  logic            frame_full;
  logic [1:0]      last_byte;
  logic            pix_done;
  logic [7:0]      count_raw;
  logic            rem_small;
  logic            clip;
  logic [7:0]      count;
  logic [2:0][7:0] px_new;

  // Derived values shared by both blocks below.
  always_comb begin
    cur = state_i;
    if (frame_start_i) begin
      cur = '0;
    end
    diff       = {1'b0, pixel_total_i} - {1'b0, cur.idx};
    remaining  = diff[31:0];
    frame_full = diff[32] || (remaining == 32'd0);
    last_byte  = four_byte_i ? LastByte4 : LastByte3;
    pix_done   = !frame_full && (cur.phase == PH_PIXEL) && !(cur.bip < last_byte);
    count_raw  = cur.is_run ? cur.left : 8'd1;
    rem_small  = (remaining[31:8] == 24'd0);
    clip       = rem_small && (count_raw > remaining[7:0]);
    count      = clip ? remaining[7:0] : count_raw;
    px_new     = cur.px;
    case (cur.bip)
      2'd0: px_new[0] = data_byte_i;
      2'd1: px_new[1] = data_byte_i;
      2'd2: px_new[2] = data_byte_i;
      default: px_new = cur.px;
    endcase
  end

  // Next state.
  always_comb begin
    state_o = cur;
    if (!frame_full) begin
      case (cur.phase)
        PH_HEADER: begin
          if (data_byte_i <= RunBias) begin
            state_o.is_run = 1'b0;
            state_o.left   = data_byte_i + 8'd1;
          end else begin
            state_o.is_run = 1'b1;
            state_o.left   = data_byte_i - RunBias;
          end
          state_o.bip   = 2'd0;
          state_o.phase = PH_PIXEL;
        end
        PH_PIXEL: begin
          state_o.px = px_new;
          if (!pix_done) begin
            state_o.bip = cur.bip + 2'd1;
          end else begin
            state_o.bip = 2'd0;
            state_o.idx = cur.idx + {24'd0, count};
            if (cur.is_run) begin
              state_o.left  = 8'd0;
              state_o.phase = PH_HEADER;
            end else begin
              state_o.left = cur.left - 8'd1;
              if (cur.left == 8'd1) begin
                state_o.phase = PH_HEADER;
              end
            end
          end
        end
        default: state_o = cur;
      endcase
    end
  end

  // Result item.
  always_comb begin
    item_valid_o        = pix_done;
    item_o.red          = px_new[2];
    item_o.green        = px_new[1];
    item_o.blue         = px_new[0];
    item_o.alpha        = (cur.bip == 2'd3) ? data_byte_i : 8'd0;
    item_o.repeat_count = count;
    item_o.first_index  = cur.idx;
    item_o.clipped      = clip;
    item_o.frame_done   = rem_small && (count == remaining[7:0]);
  end

endmodule

`default_nettype wire

// ===== sv/tga_rle_pixel_decoder_unit.sv =====
// Run-length TGA pixel decoder, top level: input register, decode step, result register.
// A byte is held in the input register, decoded by trd_step, and its run item loaded into the result register.
// Throughput: one byte per cycle, unless a byte that makes an item finds the result register full and not drained.
// Reset (rst_ni low, asynchronous): 24-bit pixels, pixel total 1, decoder state cleared.
// Depends on trd_pkg, trd_if (trd_in_if, trd_out_if) and trd_step.
`default_nettype none

module tga_rle_pixel_decoder_unit
  import trd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  trd_in_if.sink                 in_i,
  trd_out_if.source              out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // Configuration registers.
  logic        four_byte_q;
  logic [31:0] pixel_total_q;
  logic        cfg_write;
  reg_idx_e    cfg_idx;

  // Input register: holds one byte until the step logic consumes it.
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_data_q;
  logic       in_fs_q;
  logic       in_accept;

  // Decoder state and result register.
  dec_state_t state_q, state_d;
  run_item_t  item_d, out_q;
  logic       item_valid;
  logic       out_valid_q, out_valid_d;
  logic       advance;
  logic       out_load;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = reg_idx_e'(paddr[2]);

  always_comb begin
    case (cfg_idx)
      REG_FOUR_BYTE:   prdata = {31'd0, four_byte_q};
      REG_PIXEL_TOTAL: prdata = pixel_total_q;
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_byte_q   <= 1'b0;
      pixel_total_q <= 32'd1;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_FOUR_BYTE:   four_byte_q   <= pwdata[0];
        REG_PIXEL_TOTAL: pixel_total_q <= pwdata;
        default:         four_byte_q   <= four_byte_q;
      endcase
    end
  end

  trd_step u_step (
    .state_i       (state_q),
    .data_byte_i   (in_data_q),
    .frame_start_i (in_fs_q),
    .four_byte_i   (four_byte_q),
    .pixel_total_i (pixel_total_q),
    .state_o       (state_d),
    .item_o        (item_d),
    .item_valid_o  (item_valid)
  );

  // Advance the held byte unless it makes an item and the result register is
  // full and not being drained this cycle.
  assign advance    = in_valid_q && (!item_valid || !out_valid_q || out_o.ready);
  assign out_load   = advance && item_valid;
  assign in_i.ready = !in_valid_q || advance;
  assign in_accept  = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers: no reset, qualified by the valid flags.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_data_q <= in_i.data_byte;
      in_fs_q   <= in_i.frame_start;
    end
    if (out_load) begin
      out_q <= item_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.red          = out_q.red;
  assign out_o.green        = out_q.green;
  assign out_o.blue         = out_q.blue;
  assign out_o.alpha        = out_q.alpha;
  assign out_o.repeat_count = out_q.repeat_count;
  assign out_o.first_index  = out_q.first_index;
  assign out_o.clipped      = out_q.clipped;
  assign out_o.frame_done   = out_q.frame_done;

  // A clipped run always ends the image.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.clipped |-> out_q.frame_done)
    else $error("clipped run without frame completion");

  // Pixel phase always has pixels left in the packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_PIXEL |-> state_q.left != 8'd0)
    else $error("pixel phase with empty packet");

  // Loading a frame-completing item leaves the pixel index at the total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && item_d.frame_done |=> state_q.idx == pixel_total_q)
    else $error("frame done but pixel index not at total");

  // Never overwrite a result that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || out_o.ready)
    else $error("result register overwritten");

endmodule

`default_nettype wire

// ===== tb/tb_tga_rle_pixel_decoder_unit.sv =====
// Self-checking testbench for the run-length TGA pixel decoder: directed and random byte streams.
// Depends on trd_pkg, trd_if and tga_rle_pixel_decoder_unit; decoded runs are predicted here.

class tga_run_tracker;
  // Decoder configuration and state, kept in step with the block.
  logic                four_byte;
  logic [31:0]         total;
  trd_pkg::phase_e     phase;
  logic                is_run;
  logic [7:0]          left;
  logic [1:0]          bip;
  logic [2:0][7:0]     px;
  logic [31:0]         idx;
  trd_pkg::run_item_t  pending_runs[$];
  int                  errors;

  function new();
    four_byte = 1'b0;
    total = 32'd1;
    errors = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    phase = trd_pkg::PH_HEADER;
    is_run = 1'b0;
    left = 8'd0;
    bip = 2'd0;
    px = '0;
    idx = 32'd0;
  endfunction

  function void set_reg(trd_pkg::reg_idx_e r, logic [31:0] v);
    if (r == trd_pkg::REG_FOUR_BYTE) four_byte = v[0];
    else total = v;
  endfunction

  // Note one accepted byte and queue the run item it completes, if any.
  function void decode_byte(logic [7:0] b, logic fs);
    logic [1:0]         last;
    logic [31:0]        cnt;
    logic [31:0]        rem;
    trd_pkg::run_item_t r;
    last = four_byte ? trd_pkg::LastByte4 : trd_pkg::LastByte3;
    if (fs) clear_frame();
    if (idx >= total) return;
    if (phase == trd_pkg::PH_HEADER) begin
      if (b <= trd_pkg::RunBias) begin
        is_run = 1'b0;
        left = b + 8'd1;
      end else begin
        is_run = 1'b1;
        left = b - trd_pkg::RunBias;
      end
      bip = 2'd0;
      phase = trd_pkg::PH_PIXEL;
      return;
    end
    if (bip < 2'd3) px[bip] = b;
    if (bip < last) begin
      bip = bip + 2'd1;
      return;
    end
    r.alpha = (bip == 2'd3) ? b : 8'd0;
    bip = 2'd0;
    cnt = is_run ? {24'd0, left} : 32'd1;
    rem = total - idx;
    r.clipped = (cnt > rem);
    if (r.clipped) cnt = rem;
    r.frame_done = (cnt == rem);
    r.red = px[2];
    r.green = px[1];
    r.blue = px[0];
    r.repeat_count = cnt[7:0];
    r.first_index = idx;
    pending_runs.push_back(r);
    idx = idx + cnt;
    if (is_run) begin
      left = 8'd0;
      phase = trd_pkg::PH_HEADER;
    end else begin
      left = left - 8'd1;
      if (left == 8'd0) phase = trd_pkg::PH_HEADER;
    end
  endfunction

  function void check_run(trd_pkg::run_item_t got);
    trd_pkg::run_item_t want;
    if (pending_runs.size() == 0) begin
      $display("%0t unexpected run item: actual %p", $time, got);
      errors++;
      return;
    end
    want = pending_runs.pop_front();
    if (got !== want) begin
      $display("%0t run item mismatch: expected %p actual %p", $time, want, got);
      errors++;
    end
  endfunction
endclass

module tb_tga_rle_pixel_decoder_unit;
  import trd_pkg::*;

  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [7:0] data;
    logic       fs;
  } byte_item_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  trd_in_if  in_if();
  trd_out_if out_if();

  tga_rle_pixel_decoder_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tga_run_tracker tracker;
  byte_item_t     byte_q[$];
  int             send_idle_pct;
  int             recv_stall_pct;
  int             hold_seq;
  int             cycles;
  int             cfg_errors;

  // Bring up every input at a known value before the first edge.
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.data_byte = 8'd0;
    in_if.frame_start = 1'b0;
    out_if.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_seq = 0;
    cfg_errors = 0;
    tracker = new();
  end

  always #10 clk_i = ~clk_i;

  // Watchdog: abandon the run if it has clearly stopped making progress.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end
  initial cycles = 0;

  // Receiver: stall at random, or hold off for a long stretch when asked.
  always @(negedge clk_i) begin : recv_proc
    int seen_seq;
    int hold_left;
    if (hold_seq != seen_seq) begin
      seen_seq = hold_seq;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check the result transaction first, then note the byte transaction.
  // A byte accepted at this edge cannot produce the result seen at the same edge.
  always @(posedge clk_i) begin : mon_proc
    run_item_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.red = out_if.red;
      got.green = out_if.green;
      got.blue = out_if.blue;
      got.alpha = out_if.alpha;
      got.repeat_count = out_if.repeat_count;
      got.first_index = out_if.first_index;
      got.clipped = out_if.clipped;
      got.frame_done = out_if.frame_done;
      tracker.check_run(got);
    end
    if (rst_ni && in_if.valid && in_if.ready)
      tracker.decode_byte(in_if.data_byte, in_if.frame_start);
  end

  // Write a register with a setup and an access cycle, then read it back.
  task automatic write_reg(reg_idx_e r, logic [31:0] v);
    logic [31:0] want;
    want = (r == REG_FOUR_BYTE) ? {31'd0, v[0]} : v;
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {r, 2'b00};
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    tracker.set_reg(r, v);
    @(negedge clk_i);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      $display("%0t register %s readback: expected %h actual %h", $time, r.name(), want, prdata);
      cfg_errors++;
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic push_byte(logic [7:0] d, logic fs);
    byte_item_t it;
    it.data = d;
    it.fs = fs;
    byte_q.push_back(it);
  endtask

  // Offer every queued byte, idling at random between transactions.
  task automatic send_bytes();
    byte_item_t it;
    while (byte_q.size() > 0) begin
      it = byte_q.pop_front();
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) begin
        in_if.valid = 1'b0;
        in_if.data_byte = 8'($urandom);
        @(negedge clk_i);
      end
      in_if.valid = 1'b1;
      in_if.data_byte = it.data;
      in_if.frame_start = it.fs;
      do @(posedge clk_i); while (!in_if.ready);
    end
    @(negedge clk_i);
    in_if.valid = 1'b0;
    in_if.frame_start = 1'b0;
  endtask

  // Wait for every predicted run, then let a byte still in flight clear the block.
  task automatic drain();
    while (tracker.pending_runs.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Build well-formed frames with random content, broken off where the budget ends,
  // with bursts of noise in between.
  task automatic build_stream(int budget, logic four, logic [31:0] tot);
    int target;
    int pixels;
    int n;
    int k;
    int bpp;
    bpp = four ? 4 : 3;
    target = (tot > 32'd400) ? 400 : int'(tot);
    while (byte_q.size() < budget) begin
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) push_byte(8'($urandom), ($urandom_range(7) == 0));
      end else begin
        pixels = 0;
        k = 1;
        while (pixels < target && byte_q.size() < budget) begin
          if ($urandom_range(1)) begin
            n = ($urandom_range(19) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
            push_byte(8'(n - 1), k[0]);
            repeat (n * bpp) push_byte(8'($urandom), 1'b0);
          end else begin
            n = $urandom_range(1, 128);
            push_byte(8'(n + 127), k[0]);
            repeat (bpp) push_byte(8'($urandom), 1'b0);
          end
          k = 0;
          pixels += n;
        end
        // Trailing bytes after the frame, ignored by the block if the frame is complete.
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  initial begin : main_proc
    logic        four;
    logic [31:0] tot;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Raw pixel at the byte extremes, then a full-length run clipped to the end of
    // the frame, then a trailing byte once the frame is complete.
    write_reg(REG_FOUR_BYTE, 32'd0);
    write_reg(REG_PIXEL_TOTAL, 32'd6);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h11, 1'b0); push_byte(8'h22, 1'b0); push_byte(8'h33, 1'b0);
    push_byte(8'h7F, 1'b0);
    send_bytes();
    drain();

    // Four-byte pixels: a raw packet running past the end leaves ignored pixels.
    write_reg(REG_FOUR_BYTE, 32'd1);
    write_reg(REG_PIXEL_TOTAL, 32'd2);
    push_byte(8'h02, 1'b1);
    push_byte(8'h01, 1'b0); push_byte(8'h02, 1'b0); push_byte(8'h03, 1'b0);
    push_byte(8'h04, 1'b0);
    push_byte(8'h05, 1'b0); push_byte(8'h06, 1'b0); push_byte(8'h07, 1'b0);
    push_byte(8'h08, 1'b0);
    push_byte(8'h09, 1'b0);
    send_bytes();
    drain();

    // Total of FFFE_0001 hex; change the pixel size halfway through a run pixel.
    write_reg(REG_PIXEL_TOTAL, 32'hFFFE_0001);
    push_byte(8'h80, 1'b1);
    push_byte(8'hA1, 1'b0); push_byte(8'hB2, 1'b0);
    send_bytes();
    drain();
    write_reg(REG_FOUR_BYTE, 32'd0);
    push_byte(8'hC3, 1'b0);
    send_bytes();
    drain();

    // A zero total counts as complete at once: every byte is dropped.
    write_reg(REG_PIXEL_TOTAL, 32'd0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h10, 1'b0); push_byte(8'h20, 1'b0); push_byte(8'h30, 1'b0);
    send_bytes();
    drain();

    // Random phases: cycle through the idling patterns and a range of settings.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin four = 1'b0; tot = 32'd1; end
        1: begin four = 1'b1; tot = 32'hFFFE_0001; end
        2: begin four = 1'b0; tot = $urandom_range(2, 40); end
        3: begin four = 1'b1; tot = $urandom_range(2, 40); end
        4: begin four = 1'b0; tot = $urandom; end
        5: begin four = 1'b1; tot = $urandom_range(40, 300); end
        6: begin four = 1'b0; tot = $urandom_range(1, 20); end
        default: begin four = 1'b1; tot = $urandom_range(1, 20); end
      endcase
      write_reg(REG_FOUR_BYTE, {31'd0, four});
      write_reg(REG_PIXEL_TOTAL, tot);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      // Hold the receiver off while the sender keeps offering, so the block backs up.
      if (ph == 1) hold_seq++;
      build_stream(85, four, tot);
      send_bytes();
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (tracker.errors == 0 && cfg_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
